// ===== sv/paged_lcd_pixel_writer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the paged LCD pixel writer
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAGED_LCD_PIXEL_WRITER_UNIT_MACROS_SVH
`define PAGED_LCD_PIXEL_WRITER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLCD_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLCD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/plcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Paged LCD pixel writer package
// Request and response types, queue entry types and controller codes.
// ----------------------------------------------------------------------------
package plcd_pkg;

   // One pixel write request.
   typedef struct packed {
      logic [6:0] pixel_x;
      logic [6:0] pixel_y;
      logic       pixel_on;
   } req_type;

   // One controller word.
   typedef struct packed {
      logic       is_data;
      logic [7:0] word_byte;
      logic       last_word;
   } rsp_type;

   // A classified pixel write waiting for the back end.
   typedef struct packed {
      logic [6:0] col;
      logic [3:0] page;
      logic [2:0] row_bit;
      logic       pixel_on;
   } q_entry_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

   // Position within the four controller words of one pixel.
   typedef enum logic [1:0] {
      WORD_PAGE     = 2'd0,
      WORD_COL_HIGH = 2'd1,
      WORD_COL_LOW  = 2'd2,
      WORD_DATA     = 2'd3
   } word_type;

   // Controller command codes.
   localparam logic [7:0] CMD_PAGE_ADDR = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] COL_LOW_MASK  = 8'h0F;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

endpackage

// ===== sv/paged_lcd_pixel_writer_unit.sv =====
// ----------------------------------------------------------------------------
// Paged LCD pixel writer
// Keeps a shadow frame of page bytes and turns each pixel write into the
// four controller words that rewrite the affected byte on the panel.
//
//   Channel  Ports                          Moves
//   request  req_valid req_stall req_data   one pixel write (x, y, on)
//   response rsp_valid rsp_stall rsp_data   one controller word
//
// After reset the frame memory is swept clear, one byte per cycle, over
// PANEL_COLUMNS * ceil(PANEL_ROWS / 8) bytes (864 at the defaults);
// req_stall stays high for that time.
// In the back end each pixel on the panel first updates its byte from the
// registered read, then sends four words, each held while rsp_stall is
// high; a pixel that finds the back end idle first waits for the queue pop.
// Pixels off the panel are taken and give no words.
// A two-entry queue lets requests arrive while words wait on rsp_stall.
// ----------------------------------------------------------------------------
`include "paged_lcd_pixel_writer_unit_macros.svh"

module paged_lcd_pixel_writer_unit #(
   parameter int PANEL_COLUMNS = 96,
   parameter int PANEL_ROWS    = 68
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plcd_pkg::rsp_type rsp_data
);

   logic                  clear_active;
   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   plcd_pkg::q_entry_type q_entry;
   plcd_pkg::q_head_type  q_head;

   // Front end: accept and classify.
   plcd_front #(
      .PANEL_COLUMNS(PANEL_COLUMNS),
      .PANEL_ROWS   (PANEL_ROWS)
   ) u_front (
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .clear_active(clear_active),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // Queue between the two halves.
   plcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full)
   );

   // Back end: frame update and word sequencing.
   plcd_back #(
      .PANEL_COLUMNS(PANEL_COLUMNS),
      .PANEL_ROWS   (PANEL_ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .clear_active(clear_active),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // Checks on the queue and the word sequence.
   `PLCD_ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "push into a full queue")
   `PLCD_ASSERT_SAME(a_no_words_in_clear, clear_active, !rsp_valid && !q_pop, "busy in clear")
   `PLCD_ASSERT_SAME(a_last_is_data, rsp_valid && rsp_data.last_word, rsp_data.is_data, "last not data")
   `PLCD_ASSERT_NEXT(a_pop_then_no_word, q_pop, !rsp_valid, "word sent while byte is fetched")

endmodule

// ===== sv/plcd_front.sv =====
// ----------------------------------------------------------------------------
// Pixel writer front end
// Accepts pixel requests, drops those off the panel and splits the rest
// into column, page and row bit for the queue.
// ----------------------------------------------------------------------------
module plcd_front #(
   parameter int PANEL_COLUMNS = 96,
   parameter int PANEL_ROWS    = 68
) (
   input  logic                 req_valid,
   input  plcd_pkg::req_type    req_data,
   output logic                 req_stall,
   input  logic                 clear_active,
   input  logic                 q_full,
   output logic                 q_push,
   output plcd_pkg::q_entry_type q_entry
);

   logic in_range;
   logic accept;

   // Hold off requests while the frame is being cleared or the queue is full.
   assign req_stall = clear_active | q_full;
   assign accept    = req_valid & ~req_stall;

   // A pixel outside the panel is taken and discarded.
   assign in_range = ({1'b0, req_data.pixel_x} < 8'(PANEL_COLUMNS)) &&
                     ({1'b0, req_data.pixel_y} < 8'(PANEL_ROWS));
   assign q_push   = accept & in_range;

   // Split the pixel position into page and bit within the page byte.
   always_comb begin
      q_entry.col      = req_data.pixel_x;
      q_entry.page     = req_data.pixel_y[6:3];
      q_entry.row_bit  = req_data.pixel_y[2:0];
      q_entry.pixel_on = req_data.pixel_on;
   end

endmodule

// ===== sv/plcd_queue.sv =====
// ----------------------------------------------------------------------------
// Pixel writer queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module plcd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  plcd_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output plcd_pkg::q_head_type  head,
   output logic                  full
);

   plcd_pkg::q_entry_type entries_ff [plcd_pkg::QUEUE_DEPTH];
   logic [plcd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [plcd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [plcd_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == plcd_pkg::QCNT_W'(plcd_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/plcd_back.sv =====
// ----------------------------------------------------------------------------
// Pixel writer back end
// Owns the shadow frame memory, clears it after reset, updates one page
// byte per pixel and sends the four controller words.
// ----------------------------------------------------------------------------
module plcd_back #(
   parameter int PANEL_COLUMNS = 96,
   parameter int PANEL_ROWS    = 68
) (
   input  logic                 clock,
   input  logic                 reset,
   input  plcd_pkg::q_head_type q_head,
   output logic                 q_pop,
   output logic                 clear_active,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output plcd_pkg::rsp_type    rsp_data
);

   localparam int PAGE_COUNT  = (PANEL_ROWS + 7) / 8;
   localparam int FRAME_BYTES = PAGE_COUNT * PANEL_COLUMNS;
   localparam int IDX_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOAD  = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      clr_ff, clr_in;
   plcd_pkg::word_type    word_ff, word_in;
   plcd_pkg::q_entry_type cur_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [7:0]            value_ff;
   logic [7:0]            rd_data_ff;
   logic [7:0]            frame_mem [FRAME_BYTES];

   logic [IDX_W-1:0]      head_idx;
   logic [7:0]            bit_mask;
   logic [7:0]            new_byte;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [7:0]            mem_wdata;

   // Byte address of the queue head: page * columns + column.
   assign head_idx = IDX_W'(q_head.entry.page) * IDX_W'(PANEL_COLUMNS) +
                     IDX_W'(q_head.entry.col);

   // Set or clear the pixel's bit in the byte just read.
   assign bit_mask = 8'd1 << cur_ff.row_bit;
   assign new_byte = cur_ff.pixel_on ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);

   assign clear_active = (state_ff == ST_CLEAR);
   assign rsp_valid    = (state_ff == ST_SEND);

   // Sequencer: clear sweep, then fetch, update and send per pixel.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      word_in   = word_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == IDX_W'(FRAME_BYTES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = new_byte;
            word_in   = plcd_pkg::WORD_PAGE;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (word_ff == plcd_pkg::WORD_DATA) begin
                  if (q_head.valid) begin
                     q_pop    = 1'b1;
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  word_in = plcd_pkg::word_type'(word_ff + 2'd1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         word_ff  <= plcd_pkg::WORD_PAGE;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         word_ff  <= word_in;
      end
   end

   // Current pixel and its updated byte.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head.entry;
         idx_ff <= head_idx;
      end
      if (state_ff == ST_LOAD) begin
         value_ff <= new_byte;
      end
   end

   // Frame memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= frame_mem[head_idx];
   end

   // Controller word for the current position.
   always_comb begin
      rsp_data.is_data   = 1'b0;
      rsp_data.last_word = 1'b0;
      unique case (word_ff)
         plcd_pkg::WORD_PAGE: begin
            rsp_data.word_byte = plcd_pkg::CMD_PAGE_ADDR | {4'd0, cur_ff.page};
         end
         plcd_pkg::WORD_COL_HIGH: begin
            rsp_data.word_byte = plcd_pkg::CMD_COL_HIGH | {5'd0, cur_ff.col[6:4]};
         end
         plcd_pkg::WORD_COL_LOW: begin
            rsp_data.word_byte = {1'b0, cur_ff.col} & plcd_pkg::COL_LOW_MASK;
         end
         plcd_pkg::WORD_DATA: begin
            rsp_data.is_data   = 1'b1;
            rsp_data.word_byte = value_ff;
            rsp_data.last_word = 1'b1;
         end
         default: begin
            rsp_data.word_byte = '0;
         end
      endcase
   end

endmodule
